>>> rtl/rdd_pkg.sv
`timescale 1ns / 1ps
// Package for the reversible deque drain block: item types, command and status
// codes, default sizes. No dependencies.
package rdd_pkg;

  localparam int DEPTH_DEFAULT      = 1024;
  localparam int VALUE_BITS_DEFAULT = 16;

  // Field widths of the item ports
  localparam int FIELD_BITS = 16;

  // Command codes
  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_REVERSE = 2'd1,
    OP_DELETE  = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_VALID = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_ERROR = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]            op;
    logic [FIELD_BITS-1:0] value;
  } request_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] element;
    logic [1:0]            status;
    logic                  last;
  } result_t;

endpackage

>>> rtl/rdd_ram.sv
`timescale 1ns / 1ps
// Simple dual-port element store: one write port, one read port with
// registered read data. Uses no package.
module rdd_ram #(
  parameter int DEPTH      = 1024,
  parameter int VALUE_BITS = 16,
  localparam int PW        = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [PW-1:0]         waddr,
  input  logic [VALUE_BITS-1:0] wdata,
  input  logic                  re,
  input  logic [PW-1:0]         raddr,
  output logic [VALUE_BITS-1:0] rdata
);

  logic [VALUE_BITS-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/reversible_deque_drain_top.sv
`timescale 1ns / 1ps
// Reversible deque drain top level: control, pointers and result register.
// Depends on rdd_pkg and rdd_ram.
//
// A deque in a ring buffer with a lazy direction flag. An item is taken when
// start is high and busy is low. Append, reverse and delete items give no
// result. For a read item the element store is read, if it holds an element,
// at the edge that accepts the item, and the result appears on the cycle
// after, with done high for exactly that one cycle while busy holds off the
// next item. The receiver cannot stall; it must take the result in the cycle
// that done marks. The registered read data of the store is why reads need
// the response state.
module reversible_deque_drain_top #(
  parameter int DEPTH      = rdd_pkg::DEPTH_DEFAULT,
  parameter int VALUE_BITS = rdd_pkg::VALUE_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rdd_pkg::request_t request,
  output logic              done,
  output rdd_pkg::result_t  result
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int FB = rdd_pkg::FIELD_BITS;
  localparam int XW = (VALUE_BITS > FB) ? VALUE_BITS : FB;
  localparam logic [PW:0]   DEPTH_P = (PW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RESP = 2'b10
  } state_t;

  state_t        state, state_next;
  logic [PW-1:0] head_ptr, head_ptr_next;
  logic [CW-1:0] count, count_next;
  logic          reversed, reversed_next;
  logic          error_flag, error_flag_next;
  logic [1:0]    res_status, res_status_next;
  logic          res_last, res_last_next;

  logic                  accept;
  logic                  we, re;
  logic [PW-1:0]         waddr, raddr;
  logic [VALUE_BITS-1:0] wdata, rdata;
  logic [PW-1:0]         offset;
  logic [PW:0]           idx_sum;
  logic [PW-1:0]         ring_idx;
  logic [PW-1:0]         head_inc;
  logic [XW-1:0]         value_x;
  logic [XW-1:0]         rdata_x;

  assign accept = start && !busy;
  assign busy   = (state == S_RESP);
  assign done   = (state == S_RESP);

  // Ring index: head plus offset, wrapped once
  always_comb begin
    if (rdd_pkg::op_t'(request.op) == rdd_pkg::OP_APPEND) begin
      offset = count[PW-1:0];
    end else begin
      offset = PW'(count - CW'(1));
    end
    idx_sum = {1'b0, head_ptr} + {1'b0, offset};
    if (idx_sum >= DEPTH_P) begin
      ring_idx = PW'(idx_sum - DEPTH_P);
    end else begin
      ring_idx = idx_sum[PW-1:0];
    end
    if ({1'b0, head_ptr} == DEPTH_P - (PW + 1)'(1)) begin
      head_inc = '0;
    end else begin
      head_inc = head_ptr + PW'(1);
    end
  end

  // Value resized to the stored width
  assign value_x = XW'(request.value);
  assign wdata   = value_x[VALUE_BITS-1:0];
  assign waddr   = ring_idx;
  assign raddr   = reversed ? ring_idx : head_ptr;

  // Command decode and state update
  always_comb begin
    state_next      = state;
    head_ptr_next   = head_ptr;
    count_next      = count;
    reversed_next   = reversed;
    error_flag_next = error_flag;
    res_status_next = res_status;
    res_last_next   = res_last;
    we              = 1'b0;
    re              = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (rdd_pkg::op_t'(request.op))
            rdd_pkg::OP_APPEND: begin
              if (count != DEPTH_C) begin
                we         = 1'b1;
                count_next = count + CW'(1);
              end
            end
            rdd_pkg::OP_REVERSE: begin
              if (!error_flag) reversed_next = !reversed;
            end
            rdd_pkg::OP_DELETE: begin
              if (!error_flag) begin
                if (count == '0) begin
                  error_flag_next = 1'b1;
                end else begin
                  count_next = count - CW'(1);
                  if (!reversed) head_ptr_next = head_inc;
                end
              end
            end
            rdd_pkg::OP_READ: begin
              state_next    = S_RESP;
              res_last_next = 1'b1;
              if (error_flag) begin
                res_status_next = rdd_pkg::STAT_ERROR;
                count_next      = '0;
                head_ptr_next   = '0;
                error_flag_next = 1'b0;
                reversed_next   = 1'b0;
              end else if (count == '0) begin
                res_status_next = rdd_pkg::STAT_EMPTY;
                reversed_next   = 1'b0;
              end else begin
                re              = 1'b1;
                res_status_next = rdd_pkg::STAT_VALID;
                count_next      = count - CW'(1);
                if (!reversed) head_ptr_next = head_inc;
                if (count == CW'(1)) begin
                  reversed_next = 1'b0;
                end else begin
                  res_last_next = 1'b0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head_ptr   <= '0;
      count      <= '0;
      reversed   <= 1'b0;
      error_flag <= 1'b0;
    end else begin
      state      <= state_next;
      head_ptr   <= head_ptr_next;
      count      <= count_next;
      reversed   <= reversed_next;
      error_flag <= error_flag_next;
    end
  end

  // Result fields held for the response cycle
  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_last   <= res_last_next;
  end

  rdd_ram #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Result: element only on a valid status
  assign rdata_x = XW'(rdata);
  always_comb begin
    result.status = res_status;
    result.last   = res_last;
    if (rdd_pkg::status_t'(res_status) == rdd_pkg::STAT_VALID) begin
      result.element = rdata_x[FB-1:0];
    end else begin
      result.element = '0;
    end
  end

endmodule
